// File: sv/ggvc_pkg.sv
`default_nettype none
package ggvc_pkg;

  localparam int CW = 36;
  localparam int ZW = 32;
  localparam int TABLE_LEN = 24;
  localparam int GUARD_BITS = 6;
  localparam int ANGLE_BITS = 28;

  localparam logic signed [ZW-1:0] PI_Q28 = 32'sd843314857;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  localparam logic [2:0] REG_GOAL_X    = 3'd0;
  localparam logic [2:0] REG_GOAL_Y    = 3'd1;
  localparam logic [2:0] REG_TOLERANCE = 3'd2;
  localparam logic [2:0] REG_MIN_SPEED = 3'd3;
  localparam logic [2:0] REG_MAX_SPEED = 3'd4;
  localparam logic [2:0] REG_TURN_GAIN = 3'd5;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    vec_t b;
    vec_t h;
  } pair_t;

  function automatic logic signed [ZW-1:0] atan_q28(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 32'sd210828714;
      1: r = 32'sd124459457;
      2: r = 32'sd65760959;
      3: r = 32'sd33381290;
      4: r = 32'sd16755422;
      5: r = 32'sd8385879;
      6: r = 32'sd4193963;
      7: r = 32'sd2097109;
      8: r = 32'sd1048571;
      9: r = 32'sd524287;
      10: r = 32'sd262144;
      11: r = 32'sd131072;
      12: r = 32'sd65536;
      13: r = 32'sd32768;
      14: r = 32'sd16384;
      15: r = 32'sd8192;
      16: r = 32'sd4096;
      17: r = 32'sd2048;
      18: r = 32'sd1024;
      19: r = 32'sd512;
      20: r = 32'sd256;
      21: r = 32'sd128;
      22: r = 32'sd64;
      23: r = 32'sd32;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/ggvc_if.sv
`default_nettype none
interface ggvc_pose_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [15:0] orient_z;
  logic signed [15:0] orient_w;
  modport source (output valid, pos_x, pos_y, orient_z, orient_w, input ready);
  modport sink   (input valid, pos_x, pos_y, orient_z, orient_w, output ready);
endinterface

interface ggvc_cmd_if;
  logic               valid;
  logic               ready;
  logic        [22:0] fwd_speed;
  logic signed [23:0] turn_rate;
  logic               goal_reached;
  modport source (output valid, fwd_speed, turn_rate, goal_reached,
                  input ready);
  modport sink   (input valid, fwd_speed, turn_rate, goal_reached,
                  output ready);
endinterface

interface ggvc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/ggvc_cordic_cell.sv
`default_nettype none
module ggvc_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ggvc_pkg::pair_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ggvc_pkg::pair_t      out_data
);

  localparam logic signed [ggvc_pkg::ZW-1:0] ATAN = ggvc_pkg::atan_q28(STEP);

  ggvc_pkg::pair_t data_next;

  function automatic ggvc_pkg::vec_t rotate(input ggvc_pkg::vec_t v);
    ggvc_pkg::vec_t r;
    logic signed [ggvc_pkg::CW-1:0] xs;
    logic signed [ggvc_pkg::CW-1:0] ys;
    xs = v.x >>> STEP;
    ys = v.y >>> STEP;
    r = v;
    if (!v.y[ggvc_pkg::CW-1]) begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + ATAN;
    end else begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - ATAN;
    end
    return r;
  endfunction

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next.b = rotate(in_data.b);
    data_next.h = rotate(in_data.h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/go_to_goal_velocity_controller_unit.sv
// Go-to-goal proportional controller.
// pose (sink): one beat per pose sample, x/y position in Q(FRAC_BITS) and
//   quaternion z/w in Q1.15. cmd (source): one beat per pose beat, in order,
//   with linear and angular speed and the goal-reached flag.
// cfg (sink): register writes, index 0..5 = goal_x, goal_y, tolerance,
//   min_speed, max_speed, turn_gain; other indexes are ignored. Always ready.
//   Write only while no pose beat is in flight.
// Distance, bearing and heading come from min(CORDIC_ITERATIONS, TABLE_LEN)
//   cells, each doing one vectoring step on two vectors and passing them on.
// A pose beat passes the operand stage, the pre-rotation stage, the cells,
//   the multiply stage and the output register on its way to a cmd beat.
// Throughput: one beat per cycle unless cmd stalls; every stage has its own
//   valid bit: bubbles close up, the input keeps flowing into empty stages.
// A stalled cmd beat holds in the output register; stages behind it fill
//   and pose.ready drops only when all of them hold data.
// Reset clears all valid bits and loads the default register values.
`default_nettype none
module go_to_goal_velocity_controller_unit #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int FRAC_BITS = 12
) (
  input wire logic clk,
  input wire logic rst,
  ggvc_pose_if.sink  pose,
  ggvc_cmd_if.source cmd,
  ggvc_cfg_if.sink   cfg
);

  localparam int N = (CORDIC_ITERATIONS < ggvc_pkg::TABLE_LEN) ?
                     CORDIC_ITERATIONS : ggvc_pkg::TABLE_LEN;
  localparam logic [23:0] GOAL_RST = 24'(3 << FRAC_BITS);
  localparam logic [22:0] TOL_RST  = 23'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [22:0] MIN_RST  = 23'((8 * (1 << FRAC_BITS) + 50) / 100);
  localparam logic [22:0] MAX_RST  = 23'((2 * (1 << FRAC_BITS) + 5) / 10);
  localparam int SH = ggvc_pkg::ANGLE_BITS + 8 - FRAC_BITS;
  localparam logic signed [43:0] RND = 44'sd1 <<< (SH - 1);

  logic signed [23:0] goal_x;
  logic signed [23:0] goal_y;
  logic [22:0] tolerance;
  logic [22:0] min_speed;
  logic [22:0] max_speed;
  logic [9:0]  turn_gain;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x    <= GOAL_RST;
      goal_y    <= GOAL_RST;
      tolerance <= TOL_RST;
      min_speed <= MIN_RST;
      max_speed <= MAX_RST;
      turn_gain <= 10'd128;
    end else if (cfg.valid) begin
      case (cfg.index)
        ggvc_pkg::REG_GOAL_X:    goal_x    <= cfg.data;
        ggvc_pkg::REG_GOAL_Y:    goal_y    <= cfg.data;
        ggvc_pkg::REG_TOLERANCE: tolerance <= cfg.data[22:0];
        ggvc_pkg::REG_MIN_SPEED: min_speed <= cfg.data[22:0];
        ggvc_pkg::REG_MAX_SPEED: max_speed <= cfg.data[22:0];
        ggvc_pkg::REG_TURN_GAIN: turn_gain <= cfg.data[9:0];
        default: ;
      endcase
    end
  end

  // operand stage
  logic a_valid, a_ready;
  logic signed [24:0] a_dx, a_dy;
  logic signed [32:0] a_hx, a_hy;
  logic signed [31:0] zz, wz;

  // pre-rotation stage
  logic b_valid, b_ready;
  ggvc_pkg::pair_t b_data;
  ggvc_pkg::pair_t b_next;

  // multiply stage
  logic m_valid, m_ready;
  logic [64:0] m_prod;
  logic signed [32:0] m_rel;

  // output register
  logic f_ready;

  logic            c_valid [N+1];
  logic            c_ready [N+1];
  ggvc_pkg::pair_t c_data  [N+1];

  assign zz = pose.orient_z * pose.orient_z;
  assign wz = pose.orient_w * pose.orient_z;

  assign pose.ready = a_ready;
  assign a_ready = !a_valid || b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= pose.valid;
    end
    if (a_ready && pose.valid) begin
      a_dx <= 25'(goal_x) - 25'(pose.pos_x);
      a_dy <= 25'(goal_y) - 25'(pose.pos_y);
      a_hx <= (33'sd1 <<< 30) - (33'(zz) <<< 1);
      a_hy <= 33'(wz) <<< 1;
    end
  end

  function automatic ggvc_pkg::vec_t prerotate(input logic signed [ggvc_pkg::CW-1:0] x,
                                               input logic signed [ggvc_pkg::CW-1:0] y);
    ggvc_pkg::vec_t v;
    v.zero = (x == '0) && (y == '0);
    v.x = x;
    v.y = y;
    v.z = '0;
    if (x[ggvc_pkg::CW-1]) begin
      v.x = -x;
      v.y = -y;
      v.z = y[ggvc_pkg::CW-1] ? -ggvc_pkg::PI_Q28 : ggvc_pkg::PI_Q28;
    end
    return v;
  endfunction

  always_comb begin
    b_next.b = prerotate(ggvc_pkg::CW'(a_dx) <<< ggvc_pkg::GUARD_BITS,
                         ggvc_pkg::CW'(a_dy) <<< ggvc_pkg::GUARD_BITS);
    b_next.h = prerotate(ggvc_pkg::CW'(a_hx), ggvc_pkg::CW'(a_hy));
  end

  assign b_ready = !b_valid || c_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      b_data <= b_next;
    end
  end

  assign c_valid[0] = b_valid;
  assign c_data[0]  = b_data;
  assign c_ready[N] = m_ready;

  for (genvar i = 0; i < N; i++) begin : g_cell
    ggvc_cordic_cell #(.STEP(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_data   (c_data[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .out_data  (c_data[i+1])
    );
  end

  ggvc_pkg::pair_t tail;
  logic [34:0] xf;
  logic signed [32:0] bearing, heading;

  assign tail    = c_data[N];
  assign xf      = tail.b.zero ? 35'd0 : tail.b.x[34:0];
  assign bearing = tail.b.zero ? 33'sd0 : 33'(tail.b.z);
  assign heading = tail.h.zero ? 33'sd0 : 33'(tail.h.z);

  assign m_ready = !m_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_ready) begin
      m_valid <= c_valid[N];
    end
    if (m_ready && c_valid[N]) begin
      m_prod <= 65'(xf) * 65'(ggvc_pkg::INV_GAIN_Q30);
      m_rel  <= bearing - heading;
    end
  end

  logic [64:0] dist_sum;
  logic [28:0] span;
  logic [28:0] lin_lo;
  logic [28:0] lin;
  logic signed [43:0] ang_prod;
  logic signed [43:0] ang_shift;
  logic signed [23:0] ang;

  always_comb begin
    dist_sum  = m_prod + (65'd1 << 35);
    span      = 29'(dist_sum >> 36);
    lin_lo    = (span > 29'(min_speed)) ? span : 29'(min_speed);
    lin       = (lin_lo > 29'(max_speed)) ? 29'(max_speed) : lin_lo;
    ang_prod  = 44'(m_rel) * $signed({34'd0, turn_gain});
    ang_shift = (ang_prod + RND) >>> SH;
    if (ang_shift > 44'sd8388607) begin
      ang = 24'sd8388607;
    end else if (ang_shift < -44'sd8388608) begin
      ang = -24'sd8388608;
    end else begin
      ang = ang_shift[23:0];
    end
  end

  assign f_ready = !cmd.valid || cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (f_ready) begin
      cmd.valid <= m_valid;
    end
    if (f_ready && m_valid) begin
      if (span < 29'(tolerance)) begin
        cmd.fwd_speed    <= '0;
        cmd.turn_rate    <= '0;
        cmd.goal_reached <= 1'b1;
      end else begin
        cmd.fwd_speed    <= lin[22:0];
        cmd.turn_rate    <= ang;
        cmd.goal_reached <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/ggvc_checker.sv
`default_nettype none
module ggvc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cmd_valid,
  input wire logic        cmd_ready,
  input wire logic [22:0] fwd_speed,
  input wire logic [23:0] turn_rate,
  input wire logic        goal_reached
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !cmd_valid)
    else $error("cmd beat right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(fwd_speed) &&
      $stable(turn_rate) && $stable(goal_reached))
    else $error("stalled cmd beat changed");

  a_reached_stop: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && goal_reached |-> fwd_speed == '0 && turn_rate == '0)
    else $error("goal reached with non-zero speed");

endmodule

bind go_to_goal_velocity_controller_unit ggvc_checker u_ggvc_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .fwd_speed    (cmd.fwd_speed),
  .turn_rate    (cmd.turn_rate),
  .goal_reached (cmd.goal_reached)
);
`default_nettype wire
